// ===== rtl/particle_resampling_wheel_top_assert.svh =====
// assertion macros for the resampling wheel checker
`ifndef PARTICLE_RESAMPLING_WHEEL_TOP_ASSERT_SVH
`define PARTICLE_RESAMPLING_WHEEL_TOP_ASSERT_SVH

// checked property, ignored while reset is asserted
`define PRW_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("prw check failed");

// checked property that also holds across reset
`define PRW_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("prw reset check failed");

`endif

// ===== rtl/prw_pkg.sv =====
// shared constants, types and codes of the resampling wheel
package prw_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int SLOT_W        = 10;
  localparam int COORD_W       = 12;
  localparam int WEIGHT_W      = 16;
  localparam int FRAC_W        = 16;
  localparam int CNT_W         = 11;
  localparam int FUNC_W        = 2;
  localparam int ENTRY_W       = 2 * COORD_W + WEIGHT_W;
  localparam int POS_W         = WEIGHT_W + 2;
  localparam int LAP_W         = WEIGHT_W + SLOT_W;
  localparam int PROD_W        = FRAC_W + WEIGHT_W;
  localparam int STEP_W        = $clog2(POS_W);

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_PARTICLES);
  localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_PARTICLES);

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DRAW  = 2'd2;

  typedef enum logic {
    REM_START,
    REM_LAP
  } prw_rem_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_ADD,
    ST_LAP,
    ST_LAPDIV,
    ST_RDIDX,
    ST_WALK,
    ST_STDIV
  } prw_state_t;

  typedef struct packed {
    logic         load_wr;
    logic         start_acc;
    logic         draw_acc;
    logic         sum_start;
    logic         sum_run;
    logic         pos_add;
    logic         pos_clr;
    logic         rem_start;
    prw_rem_sel_t rem_sel;
    logic         pos_from_rem;
    logic         idx_from_rem;
    logic         rd_idx;
    logic         walk_step;
    logic         out_load;
  } prw_cmd_t;

  typedef struct packed {
    logic dirty;
    logic sum_done;
    logic lap_zero;
    logic pos_gt_lap;
    logic rem_done;
    logic walk_stop;
  } prw_sts_t;

endpackage

// ===== rtl/particle_resampling_wheel_top.sv =====
// top level of the particle filter resampling wheel
// Resampling wheel over up to 1024 particle slots. A load word is taken in idle and
// leaves the block ready again at once. A start word runs the bit-serial remainder
// unit that reduces the random word modulo the particle count. A draw word passes
// through the multiply, add, lap check and index read states, then walks over the
// weights, reading the particle memory once per cycle. The first draw after any load
// or count write also sweeps the memory to rebuild the weight sum, and a draw whose
// position passes a whole lap also runs the remainder unit to drop whole laps. Load
// and start words are taken while a result word still waits at the output; a draw
// stalls at its end until the output register is free. The count register may be
// written only while idle.
module particle_resampling_wheel_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [prw_pkg::FUNC_W-1:0]   in_func,
  input  logic [prw_pkg::SLOT_W-1:0]   in_slot,
  input  logic [prw_pkg::COORD_W-1:0]  in_pos_x,
  input  logic [prw_pkg::COORD_W-1:0]  in_pos_y,
  input  logic [prw_pkg::WEIGHT_W-1:0] in_weight_in,
  input  logic [prw_pkg::FRAC_W-1:0]   in_random_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [prw_pkg::COORD_W-1:0]  out_x,
  output logic [prw_pkg::COORD_W-1:0]  out_y,
  output logic [prw_pkg::WEIGHT_W-1:0] out_weight,
  output logic [prw_pkg::SLOT_W-1:0]   out_slot,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [prw_pkg::CNT_W-1:0]    cfg_data
);

  prw_pkg::prw_cmd_t cmd;
  prw_pkg::prw_sts_t sts;

  assign cfg_ready = 1'b1;

  prw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  prw_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_slot         (in_slot),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_weight_in    (in_weight_in),
    .in_random_value (in_random_value),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_weight      (out_weight),
    .out_slot        (out_slot)
  );

endmodule

// ===== rtl/prw_rem.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
module prw_rem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [prw_pkg::POS_W-1:0] dvd,
  input  logic [prw_pkg::LAP_W-1:0] dvs,
  output logic                      done,
  output logic [prw_pkg::LAP_W-1:0] rem
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [prw_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [prw_pkg::POS_W-1:0]  dvd_r;
  logic [prw_pkg::LAP_W-1:0]  dvs_r;
  logic [prw_pkg::LAP_W-1:0]  rem_r;
  logic [prw_pkg::LAP_W:0]    shifted;
  logic [prw_pkg::LAP_W:0]    diff;
  logic                       ge;

  assign shifted = {rem_r, dvd_r[prw_pkg::POS_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == prw_pkg::STEP_W'(prw_pkg::POS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dvd;
      dvs_r <= dvs;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[prw_pkg::POS_W-2:0], 1'b0};
      rem_r <= ge ? diff[prw_pkg::LAP_W-1:0] : shifted[prw_pkg::LAP_W-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/prw_dp.sv =====
// datapath: particle memory, wheel registers, lap sum, multiplier and result word
module prw_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  prw_pkg::prw_cmd_t            cmd,
  output prw_pkg::prw_sts_t            sts,
  input  logic [prw_pkg::SLOT_W-1:0]   in_slot,
  input  logic [prw_pkg::COORD_W-1:0]  in_pos_x,
  input  logic [prw_pkg::COORD_W-1:0]  in_pos_y,
  input  logic [prw_pkg::WEIGHT_W-1:0] in_weight_in,
  input  logic [prw_pkg::FRAC_W-1:0]   in_random_value,
  input  logic                         cfg_wr,
  input  logic [prw_pkg::CNT_W-1:0]    cfg_data,
  output logic [prw_pkg::COORD_W-1:0]  out_x,
  output logic [prw_pkg::COORD_W-1:0]  out_y,
  output logic [prw_pkg::WEIGHT_W-1:0] out_weight,
  output logic [prw_pkg::SLOT_W-1:0]   out_slot
);

  logic [prw_pkg::ENTRY_W-1:0] mem [prw_pkg::MAX_PARTICLES];
  logic [prw_pkg::ENTRY_W-1:0] rd_data_r;
  logic [prw_pkg::SLOT_W-1:0]  rd_addr;

  logic [prw_pkg::CNT_W-1:0]    count_r;
  logic [prw_pkg::CNT_W-1:0]    n_use;
  logic [prw_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [prw_pkg::SLOT_W-1:0]   idx_r, idx_nxt;
  logic [prw_pkg::SLOT_W-1:0]   idx_wrap;
  logic [prw_pkg::CNT_W-1:0]    idx_inc;
  logic [prw_pkg::WEIGHT_W-1:0] largest_r;
  logic                         fresh_r;
  logic                         dirty_r;
  logic [prw_pkg::FRAC_W-1:0]   frac_r;
  logic [prw_pkg::PROD_W-1:0]   prod_r;
  logic [prw_pkg::LAP_W-1:0]    lap_r;
  logic [prw_pkg::CNT_W-1:0]    sw_cnt_r;
  logic                         sw_vld_r;
  logic [prw_pkg::CNT_W-1:0]    step_r;
  logic [prw_pkg::WEIGHT_W-1:0] rd_w;

  logic                         rem_done;
  logic [prw_pkg::LAP_W-1:0]    rem_val;
  logic [prw_pkg::POS_W-1:0]    rem_dvd;
  logic [prw_pkg::LAP_W-1:0]    rem_dvs;

  // a count of zero acts as one, anything above the store acts as the store size
  always_comb begin
    priority if (count_r == '0) begin
      n_use = prw_pkg::CNT_W'(1);
    end else if (count_r > prw_pkg::COUNT_MAX) begin
      n_use = prw_pkg::COUNT_MAX;
    end else begin
      n_use = count_r;
    end
  end

  assign rd_w     = rd_data_r[prw_pkg::WEIGHT_W-1:0];
  assign idx_inc  = {1'b0, idx_r} + 1'b1;
  assign idx_wrap = (idx_inc < n_use) ? idx_inc[prw_pkg::SLOT_W-1:0] : '0;

  always_comb begin
    priority if (cmd.sum_run) begin
      rd_addr = sw_cnt_r[prw_pkg::SLOT_W-1:0];
    end else if (cmd.walk_step) begin
      rd_addr = idx_wrap;
    end else begin
      rd_addr = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem[in_slot] <= {in_pos_x, in_pos_y, in_weight_in};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    pos_nxt = pos_r;
    idx_nxt = idx_r;
    if (cmd.start_acc) begin
      pos_nxt = '0;
    end
    if (cmd.pos_add) begin
      pos_nxt = pos_r + prw_pkg::POS_W'(prod_r[prw_pkg::PROD_W-1:prw_pkg::FRAC_W-1]);
      if ({1'b0, idx_r} >= n_use) begin
        idx_nxt = '0;
      end
    end
    if (cmd.pos_clr) begin
      pos_nxt = '0;
    end
    if (cmd.pos_from_rem) begin
      pos_nxt = rem_val[prw_pkg::POS_W-1:0] + 1'b1;
    end
    if (cmd.idx_from_rem) begin
      idx_nxt = rem_val[prw_pkg::SLOT_W-1:0];
    end
    if (cmd.walk_step) begin
      pos_nxt = pos_r - prw_pkg::POS_W'(rd_w);
      idx_nxt = idx_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= prw_pkg::COUNT_RESET;
      pos_r     <= '0;
      idx_r     <= '0;
      largest_r <= '0;
      fresh_r   <= 1'b1;
      dirty_r   <= 1'b1;
      sw_vld_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      idx_r <= idx_nxt;
      if (cfg_wr) begin
        count_r <= cfg_data;
      end
      if (cmd.load_wr) begin
        if (fresh_r || (in_weight_in > largest_r)) begin
          largest_r <= in_weight_in;
        end
        fresh_r <= 1'b0;
      end
      if (cmd.start_acc) begin
        fresh_r <= 1'b1;
      end
      // the lap sum goes stale on any load or count change
      if (cmd.load_wr || cfg_wr) begin
        dirty_r <= 1'b1;
      end else if (cmd.sum_start) begin
        dirty_r <= 1'b0;
      end
      if (cmd.sum_start) begin
        sw_vld_r <= 1'b0;
      end else if (cmd.sum_run) begin
        sw_vld_r <= (sw_cnt_r != n_use);
      end
    end
  end

  // sweep over the slots in use, accumulating one weight per cycle
  always_ff @(posedge clk) begin
    if (cmd.sum_start) begin
      sw_cnt_r <= '0;
      lap_r    <= '0;
    end else if (cmd.sum_run) begin
      if (sw_cnt_r != n_use) begin
        sw_cnt_r <= sw_cnt_r + 1'b1;
      end
      if (sw_vld_r) begin
        lap_r <= lap_r + prw_pkg::LAP_W'(rd_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_acc) begin
      frac_r <= in_random_value;
    end
    prod_r <= prw_pkg::PROD_W'(frac_r) * prw_pkg::PROD_W'(largest_r);
    if (cmd.rd_idx) begin
      step_r <= '0;
    end else if (cmd.walk_step) begin
      step_r <= step_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_x      <= rd_data_r[prw_pkg::ENTRY_W-1 -: prw_pkg::COORD_W];
      out_y      <= rd_data_r[prw_pkg::WEIGHT_W +: prw_pkg::COORD_W];
      out_weight <= rd_w;
      out_slot   <= idx_r;
    end
  end

  always_comb begin
    if (cmd.rem_sel == prw_pkg::REM_START) begin
      rem_dvd = prw_pkg::POS_W'(in_random_value);
      rem_dvs = prw_pkg::LAP_W'(n_use);
    end else begin
      rem_dvd = pos_r - 1'b1;
      rem_dvs = lap_r;
    end
  end

  prw_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.rem_start),
    .dvd   (rem_dvd),
    .dvs   (rem_dvs),
    .done  (rem_done),
    .rem   (rem_val)
  );

  always_comb begin
    sts.dirty      = dirty_r;
    sts.sum_done   = (sw_cnt_r == n_use) && !sw_vld_r;
    sts.lap_zero   = (lap_r == '0);
    sts.pos_gt_lap = prw_pkg::LAP_W'(pos_r) > lap_r;
    sts.rem_done   = rem_done;
    sts.walk_stop  = (pos_r <= prw_pkg::POS_W'(rd_w)) || (step_r == n_use);
  end

endmodule

// ===== rtl/prw_ctrl.sv =====
// controller: command sequencing for load, start and draw, plus the result handshake
module prw_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [prw_pkg::FUNC_W-1:0] in_func,
  output logic                       out_valid,
  input  logic                       out_ready,
  output prw_pkg::prw_cmd_t          cmd,
  input  prw_pkg::prw_sts_t          sts
);

  prw_pkg::prw_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prw_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rem_sel = prw_pkg::REM_START;
    in_ready  = 1'b0;
    unique case (state_r)
      prw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_func)
            prw_pkg::FUNC_LOAD: begin
              cmd.load_wr = 1'b1;
            end
            prw_pkg::FUNC_START: begin
              cmd.start_acc = 1'b1;
              cmd.rem_start = 1'b1;
              state_nxt     = prw_pkg::ST_STDIV;
            end
            prw_pkg::FUNC_DRAW: begin
              cmd.draw_acc = 1'b1;
              if (sts.dirty) begin
                cmd.sum_start = 1'b1;
                state_nxt     = prw_pkg::ST_SUM;
              end else begin
                state_nxt = prw_pkg::ST_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      prw_pkg::ST_SUM: begin
        cmd.sum_run = 1'b1;
        if (sts.sum_done) begin
          state_nxt = prw_pkg::ST_MUL;
        end
      end
      prw_pkg::ST_MUL: begin
        state_nxt = prw_pkg::ST_ADD;
      end
      prw_pkg::ST_ADD: begin
        cmd.pos_add = 1'b1;
        state_nxt   = prw_pkg::ST_LAP;
      end
      prw_pkg::ST_LAP: begin
        priority if (sts.lap_zero) begin
          cmd.pos_clr = 1'b1;
          state_nxt   = prw_pkg::ST_RDIDX;
        end else if (sts.pos_gt_lap) begin
          // drop whole laps before walking
          cmd.rem_start = 1'b1;
          cmd.rem_sel   = prw_pkg::REM_LAP;
          state_nxt     = prw_pkg::ST_LAPDIV;
        end else begin
          state_nxt = prw_pkg::ST_RDIDX;
        end
      end
      prw_pkg::ST_LAPDIV: begin
        cmd.rem_sel = prw_pkg::REM_LAP;
        if (sts.rem_done) begin
          cmd.pos_from_rem = 1'b1;
          state_nxt        = prw_pkg::ST_RDIDX;
        end
      end
      prw_pkg::ST_RDIDX: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = prw_pkg::ST_WALK;
      end
      prw_pkg::ST_WALK: begin
        // on a stop the read address stays on the chosen slot until the word leaves
        if (sts.walk_stop) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = prw_pkg::ST_IDLE;
          end
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      prw_pkg::ST_STDIV: begin
        if (sts.rem_done) begin
          cmd.idx_from_rem = 1'b1;
          state_nxt        = prw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = prw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/prw_checker.sv =====
// port-level checks of the resampling wheel and their binding
`include "particle_resampling_wheel_top_assert.svh"

module prw_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [prw_pkg::FUNC_W-1:0]   in_func,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [prw_pkg::COORD_W-1:0]  out_x,
  input logic [prw_pkg::COORD_W-1:0]  out_y,
  input logic [prw_pkg::WEIGHT_W-1:0] out_weight,
  input logic [prw_pkg::SLOT_W-1:0]   out_slot
);

  // a stalled result word stays put
  `PRW_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_weight) && $stable(out_slot))

  // a load never blocks the next word
  `PRW_ASSERT(a_load_keeps_ready, clk, rst_n, in_valid && in_ready && in_func == prw_pkg::FUNC_LOAD |=> in_ready)

  // a draw always leaves the block busy in the cycle after it is taken
  `PRW_ASSERT(a_draw_busy, clk, rst_n, in_valid && in_ready && in_func == prw_pkg::FUNC_DRAW |=> !in_ready)

  // a result appears only at the end of a draw
  `PRW_ASSERT(a_result_from_draw, clk, rst_n, $rose(out_valid) |-> $past(!in_ready))

  // reset leaves the block idle
  `PRW_ASSERT_RST(a_reset_idle, clk, !rst_n |=> in_ready && !out_valid)

endmodule

bind particle_resampling_wheel_top prw_checker u_prw_checker (.*);
